### hw/rtl/ssid_pkg.sv
// Shared types and constants for the sorted set insert block.
`default_nettype none

package ssid_pkg;

    // Store size and field widths
    localparam int CAPACITY    = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int RANK_W      = 6;
    localparam int COUNT_W     = 7;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CMP_W       = (RANK_W > IDX_W) ? RANK_W : IDX_W;

    // Read gather tree: cells per first-level group
    localparam int GRP_SIZE    = 8;
    localparam int NUM_GRP     = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

    // Operation codes
    typedef enum logic [0:0] {
        OP_INSERT = 1'b0,
        OP_READ   = 1'b1
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DUP   = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // Control from top level to the cell row
    typedef struct packed {
        logic ins_en;   // commit an insert this cycle
        logic rd_en;    // capture the first read gather level
    } chain_ctrl_t;

    // Status from the cell row to the top level
    typedef struct packed {
        logic dup;      // broadcast value matches a stored entry
    } chain_stat_t;

endpackage

`default_nettype wire

### hw/rtl/ssid_req_if.sv
// Request channel: operation, value and rank with valid/ready handshake.
`default_nettype none

interface ssid_req_if import ssid_pkg::*;;
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic signed [VALUE_WIDTH-1:0] value;
    logic        [RANK_W-1:0]      rank;

    modport source (output valid, output op, output value, output rank, input ready);
    modport sink   (input valid, input op, input value, input rank, output ready);
endinterface

`default_nettype wire

### hw/rtl/ssid_rsp_if.sv
// Response channel: status, read data and count with valid/ready handshake.
`default_nettype none

interface ssid_rsp_if import ssid_pkg::*;;
    logic                          valid;
    logic                          ready;
    logic        [1:0]             status;
    logic signed [VALUE_WIDTH-1:0] read_data;
    logic        [COUNT_W-1:0]     count;

    modport source (output valid, output status, output read_data, output count, input ready);
    modport sink   (input valid, input status, input read_data, input count, output ready);
endinterface

`default_nettype wire

### hw/rtl/ssid_cell.sv
// One storage cell of the sorted row: holds an entry, compares, shifts up.
`default_nettype none

module ssid_cell import ssid_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          ins_en,
    input  wire logic signed [VALUE_WIDTH-1:0] new_value,
    input  wire logic                          prev_keep,
    input  wire logic signed [VALUE_WIDTH-1:0] prev_value,
    input  wire logic                          prev_valid,
    output logic signed [VALUE_WIDTH-1:0]      value,
    output logic                               valid,
    output logic                               keep,
    output logic                               eq
);

    logic signed [VALUE_WIDTH-1:0] value_reg;
    logic signed [VALUE_WIDTH-1:0] value_next;
    logic                          valid_reg;
    logic                          valid_next;

    // Compare against the broadcast value
    assign keep  = valid_reg && (value_reg < new_value);
    assign eq    = valid_reg && (value_reg == new_value);
    assign value = value_reg;
    assign valid = valid_reg;

    // Smaller entries stay, the first larger slot takes the new value,
    // everything above takes its lower neighbor
    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ins_en && !keep)
        begin
            if (prev_keep)
            begin
                value_next = new_value;
                valid_next = 1'b1;
            end
            else
            begin
                value_next = prev_value;
                valid_next = prev_valid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Entry payload, no reset
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

### hw/rtl/ssid_chain.sv
// Row of sorted cells with duplicate detect and a two-level read gather.
`default_nettype none

module ssid_chain import ssid_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire chain_ctrl_t                   ctrl,
    input  wire logic signed [VALUE_WIDTH-1:0] new_value,
    input  wire logic        [RANK_W-1:0]      rank,
    output chain_stat_t                        stat,
    output logic signed [VALUE_WIDTH-1:0]      rd_data
);

    logic signed [VALUE_WIDTH-1:0] cell_value [CAPACITY];
    logic        [CAPACITY-1:0]    cell_valid;
    logic        [CAPACITY-1:0]    cell_keep;
    logic        [CAPACITY-1:0]    cell_eq;

    logic signed [VALUE_WIDTH-1:0] grp_reg  [NUM_GRP];
    logic signed [VALUE_WIDTH-1:0] grp_next [NUM_GRP];

    // Cell row; cell zero sees a kept neighbor below it
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            ssid_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ins_en     (ctrl.ins_en),
                .new_value  (new_value),
                .prev_keep  (1'b1),
                .prev_value (new_value),
                .prev_valid (1'b1),
                .value      (cell_value[i]),
                .valid      (cell_valid[i]),
                .keep       (cell_keep[i]),
                .eq         (cell_eq[i])
            );
        end
        else
        begin : g_rest
            ssid_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ins_en     (ctrl.ins_en),
                .new_value  (new_value),
                .prev_keep  (cell_keep[i-1]),
                .prev_value (cell_value[i-1]),
                .prev_valid (cell_valid[i-1]),
                .value      (cell_value[i]),
                .valid      (cell_valid[i]),
                .keep       (cell_keep[i]),
                .eq         (cell_eq[i])
            );
        end
    end

    assign stat.dup = |cell_eq;

    // First gather level: each group ORs its selected, valid cell
    always_comb
    begin
        for (int g = 0; g < NUM_GRP; g++)
        begin
            grp_next[g] = '0;
            for (int j = 0; j < GRP_SIZE; j++)
            begin
                if (g * GRP_SIZE + j < CAPACITY)
                begin
                    if (cell_valid[g * GRP_SIZE + j] &&
                        (CMP_W'(rank) == CMP_W'(g * GRP_SIZE + j)))
                    begin
                        grp_next[g] = grp_next[g] | cell_value[g * GRP_SIZE + j];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            for (int g = 0; g < NUM_GRP; g++)
            begin
                grp_reg[g] <= grp_next[g];
            end
        end
    end

    // Second gather level
    always_comb
    begin
        rd_data = '0;
        for (int g = 0; g < NUM_GRP; g++)
        begin
            rd_data = rd_data | grp_reg[g];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/sorted_set_insert_dedupe.sv
// Top level of the sorted set store with insert, duplicate reject and rank read.
// Keeps up to 64 distinct signed 32-bit values in ascending order in a row of
// cells. On an insert every cell compares against the broadcast value, the
// larger entries shift up one cell and the new value lands in its place; a
// duplicate returns status 1, a full store status 2. A read uses the two-level
// OR gather (registered group level, then S_READ) to bring the selected cell's
// entry out of the row; a rank at or beyond the count returns status 3
// and zero data. Each word on rsp carries the count after the operation and
// sits in an output register, so the next request is taken while it is being
// consumed. Items are handled one at a time, in order, one response each.
`default_nettype none

module sorted_set_insert_dedupe import ssid_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    ssid_req_if.sink   req,
    ssid_rsp_if.source rsp
);

    typedef enum logic [0:0] {
        S_IDLE,
        S_READ
    } state_t;

    state_t                        state_reg;
    logic                          rsp_valid_reg;
    logic        [1:0]             rsp_status_reg;
    logic signed [VALUE_WIDTH-1:0] rsp_data_reg;
    logic        [CNT_W-1:0]       count_reg;
    logic        [CNT_W-1:0]       count_next;
    logic                          rd_ok_reg;

    logic                          accept;
    logic                          is_insert;
    logic                          full;
    logic                          rd_ok;
    chain_ctrl_t                   ctrl;
    chain_stat_t                   stat;
    logic signed [VALUE_WIDTH-1:0] chain_rd_data;

    // Handshake: take a word when idle and the output slot frees up
    assign req.ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;
    assign is_insert = (req.op == OP_INSERT);
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign rd_ok     = (CNT_W + RANK_W)'(req.rank) < (CNT_W + RANK_W)'(count_reg);

    assign ctrl.ins_en = accept && is_insert && !stat.dup && !full;
    assign ctrl.rd_en  = accept && !is_insert;
    assign count_next  = ctrl.ins_en ? count_reg + 1'b1 : count_reg;

    ssid_chain u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .new_value (req.value),
        .rank      (req.rank),
        .stat      (stat),
        .rd_data   (chain_rd_data)
    );

    // Sequencer and response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rsp_valid_reg  <= 1'b0;
            count_reg      <= '0;
            rsp_status_reg <= ST_OK;
            rsp_data_reg   <= '0;
            rd_ok_reg      <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        count_reg <= count_next;
                        if (is_insert)
                        begin
                            rsp_valid_reg <= 1'b1;
                            rsp_data_reg  <= '0;
                            if (stat.dup)
                            begin
                                rsp_status_reg <= ST_DUP;
                            end
                            else if (full)
                            begin
                                rsp_status_reg <= ST_FULL;
                            end
                            else
                            begin
                                rsp_status_reg <= ST_OK;
                            end
                        end
                        else
                        begin
                            // any pending word leaves at this edge
                            rsp_valid_reg <= 1'b0;
                            rd_ok_reg     <= rd_ok;
                            state_reg     <= S_READ;
                        end
                    end
                    else if (rsp_valid_reg && rsp.ready)
                    begin
                        rsp_valid_reg <= 1'b0;
                    end
                end
                S_READ:
                begin
                    rsp_valid_reg  <= 1'b1;
                    rsp_status_reg <= rd_ok_reg ? ST_OK : ST_RANGE;
                    rsp_data_reg   <= rd_ok_reg ? chain_rd_data : '0;
                    state_reg      <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.status    = rsp_status_reg;
    assign rsp.read_data = rsp_data_reg;
    assign rsp.count     = COUNT_W'(count_reg);

endmodule

`default_nettype wire

### hw/rtl/ssid_check.sv
// Port-level checker for the sorted set block and its bind.
`default_nettype none

module ssid_check import ssid_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   rsp_valid,
    input wire logic                   rsp_ready,
    input wire logic [1:0]             status,
    input wire logic [VALUE_WIDTH-1:0] read_data,
    input wire logic [COUNT_W-1:0]     count
);

    // A pending response word stays until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped before it was taken");

    // The count never passes the capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (count <= COUNT_W'(CAPACITY)))
        else $error("count above capacity");

    // A full reject only happens at capacity
    a_full_cap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_FULL) |-> (count == COUNT_W'(CAPACITY)))
        else $error("full status below capacity");

    // Failed reads and rejects carry zero data
    a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && ((status == ST_RANGE) || (status == ST_DUP) ||
                      (status == ST_FULL)) |-> (read_data == '0))
        else $error("nonzero data on a rejected word");

endmodule

bind sorted_set_insert_dedupe ssid_check u_ssid_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .status    (rsp.status),
    .read_data (rsp.read_data),
    .count     (rsp.count)
);

`default_nettype wire

### verif/tb_sorted_set_insert_dedupe.sv
// Testbench for the sorted set store: directed table, random traffic, scoreboard check.
`default_nettype none

module tb_sorted_set_insert_dedupe import ssid_pkg::*;;

    // Extremes of the value field
    localparam logic signed [VALUE_WIDTH-1:0] V_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam logic signed [VALUE_WIDTH-1:0] V_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

    localparam int NUM_DIR      = 20;
    localparam int NUM_RANDOM   = 400;
    localparam int HOLD_AFTER   = 100;   // response words seen before the long hold-off
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 10;

    // One response word as the block should produce it
    typedef struct packed {
        status_t                       status;
        logic signed [VALUE_WIDTH-1:0] read_data;
        logic        [COUNT_W-1:0]     count;
    } result_word_t;

    // One row of the directed table; typed rows carry their own expected word
    typedef struct packed {
        op_t                           op;
        logic signed [VALUE_WIDTH-1:0] value;
        logic        [RANK_W-1:0]      rank;
        logic                          typed;
        status_t                       status;
        logic signed [VALUE_WIDTH-1:0] read_data;
        logic        [COUNT_W-1:0]     count;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;

    ssid_req_if req_ch ();
    ssid_rsp_if rsp_ch ();

    sorted_set_insert_dedupe DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the set, ascending, no repeats
    logic signed [VALUE_WIDTH-1:0] set_vals [CAPACITY];
    int                            set_size = 0;

    result_word_t expected_words [$];
    int           fail_cnt    = 0;
    int           words_seen  = 0;
    int           req_burst   = 0;
    int           rsp_burst   = 0;

    dir_row_t dir_tab [NUM_DIR] = '{
        '{OP_READ,   32'sd0,         6'd0,  1'b1, ST_RANGE, 32'sd0, 7'd0},
        '{OP_READ,   32'sd0,         6'd63, 1'b1, ST_RANGE, 32'sd0, 7'd0},
        '{OP_INSERT, 32'sd0,         6'd63, 1'b1, ST_OK,    32'sd0, 7'd1},
        '{OP_INSERT, 32'sd0,         6'd0,  1'b1, ST_DUP,   32'sd0, 7'd1},
        '{OP_INSERT, V_MIN,          6'd0,  1'b1, ST_OK,    32'sd0, 7'd2},
        '{OP_INSERT, V_MAX,          6'd0,  1'b1, ST_OK,    32'sd0, 7'd3},
        '{OP_INSERT, V_MIN,          6'd21, 1'b1, ST_DUP,   32'sd0, 7'd3},
        '{OP_INSERT, V_MAX,          6'd42, 1'b1, ST_DUP,   32'sd0, 7'd3},
        '{OP_READ,   V_MAX,          6'd0,  1'b1, ST_OK,    V_MIN,  7'd3},
        '{OP_READ,   V_MIN,          6'd2,  1'b1, ST_OK,    V_MAX,  7'd3},
        '{OP_READ,   -32'sd1,        6'd3,  1'b1, ST_RANGE, 32'sd0, 7'd3},
        '{OP_INSERT, -32'sd1,        6'd0,  1'b0, ST_OK,    32'sd0, 7'd0},
        '{OP_INSERT, 32'sd1,         6'd0,  1'b0, ST_OK,    32'sd0, 7'd0},
        '{OP_INSERT, 32'sh55555555,  6'd21, 1'b0, ST_OK,    32'sd0, 7'd0},
        '{OP_INSERT, 32'shAAAAAAAA,  6'd42, 1'b0, ST_OK,    32'sd0, 7'd0},
        '{OP_INSERT, -32'sd1,        6'd0,  1'b0, ST_OK,    32'sd0, 7'd0},
        '{OP_READ,   32'sd0,         6'd1,  1'b0, ST_OK,    32'sd0, 7'd0},
        '{OP_READ,   32'sd0,         6'd42, 1'b0, ST_OK,    32'sd0, 7'd0},
        '{OP_INSERT, 32'sh7FFFFFFE,  6'd0,  1'b0, ST_OK,    32'sd0, 7'd0},
        '{OP_READ,   32'sd0,         6'd6,  1'b0, ST_OK,    32'sd0, 7'd0}
    };

    // Clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Apply one word to the shadow set and return the response it should give
    function automatic result_word_t apply_to_set(input op_t op,
                                                  input logic signed [VALUE_WIDTH-1:0] val,
                                                  input logic [RANK_W-1:0] rnk);
        result_word_t res;
        int           pos;
        bit           dup;
        res  = '{ST_OK, '0, '0};
        pos  = 0;
        dup  = 1'b0;
        if (op == OP_INSERT)
        begin
            for (int i = 0; i < set_size; i++)
            begin
                if (set_vals[i] == val)
                    dup = 1'b1;
                if (set_vals[i] < val)
                    pos = i + 1;
            end
            if (dup)
                res.status = ST_DUP;
            else if (set_size >= CAPACITY)
                res.status = ST_FULL;
            else
            begin
                for (int i = set_size; i > pos; i--)
                    set_vals[i] = set_vals[i-1];
                set_vals[pos] = val;
                set_size++;
            end
        end
        else
        begin
            if (int'(rnk) < set_size)
                res.read_data = set_vals[rnk];
            else
                res.status = ST_RANGE;
        end
        res.count = COUNT_W'(set_size);
        return res;
    endfunction

    // Idle cycles for one word; now and then a run of back-to-back words
    function automatic int draw_idle(ref int burst);
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
        begin
            burst = $urandom_range(15, 40);
            return 0;
        end
        return $urandom_range(0, 9);
    endfunction

    // Offer one request word and return at the edge that takes it
    task automatic send_word(input op_t op,
                             input logic signed [VALUE_WIDTH-1:0] val,
                             input logic [RANK_W-1:0] rnk);
        int gap;
        gap = draw_idle(req_burst);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.op    <= op;
        req_ch.value <= val;
        req_ch.rank  <= rnk;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // Request side: reset, directed table, random traffic, drain
    initial
    begin : req_side
        op_t                           op;
        logic signed [VALUE_WIDTH-1:0] val;
        logic        [RANK_W-1:0]      rnk;
        result_word_t                  want;
        int                            top_rank;
        int                            ins_odds;

        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.op    = OP_INSERT;
        req_ch.value = '0;
        req_ch.rank  = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows
        for (int n = 0; n < NUM_DIR; n++)
        begin
            send_word(dir_tab[n].op, dir_tab[n].value, dir_tab[n].rank);
            want = apply_to_set(dir_tab[n].op, dir_tab[n].value, dir_tab[n].rank);
            if (dir_tab[n].typed)
                want = '{dir_tab[n].status, dir_tab[n].read_data, dir_tab[n].count};
            expected_words.push_back(want);
        end

        // Random traffic: fills the store, then works it while full
        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            ins_odds = (set_size < CAPACITY) ? 6 : 4;
            if ($urandom_range(0, 9) < ins_odds)
                op = OP_INSERT;
            else
                op = OP_READ;
            case ($urandom_range(0, 3))
                0: val = $urandom_range(0, 80) - 40;
                1: val = (set_size > 0) ? set_vals[$urandom_range(0, set_size - 1)] : $urandom;
                2: val = $urandom;
                default: val = ($urandom_range(0, 1) == 1) ? V_MIN + $urandom_range(0, 3)
                                                           : V_MAX - $urandom_range(0, 3);
            endcase
            // ranks near the fill level hit both the last entry and the first missing one
            top_rank = (set_size > 63) ? 63 : set_size;
            if ($urandom_range(0, 2) != 0)
                rnk = RANK_W'($urandom_range(0, top_rank));
            else
                rnk = RANK_W'($urandom_range(0, 63));
            send_word(op, val, rnk);
            expected_words.push_back(apply_to_set(op, val, rnk));
        end
        req_ch.valid <= 1'b0;

        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Response side: random stalls, one long hold-off, compare each word
    initial
    begin : rsp_side
        result_word_t want;
        int           stall;
        bit           held;

        held         = 1'b0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            if (!held && words_seen == HOLD_AFTER)
            begin
                // long hold-off so the output register and input back up
                held = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                stall = draw_idle(rsp_burst);
                if (stall > 0)
                begin
                    rsp_ch.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_ch.valid);
            words_seen++;

            if (expected_words.size() == 0)
            begin
                $error("unexpected response word: status %0d read_data %0d count %0d",
                       rsp_ch.status, rsp_ch.read_data, rsp_ch.count);
                fail_cnt++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (rsp_ch.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
                    fail_cnt++;
                end
                if (rsp_ch.read_data !== want.read_data)
                begin
                    $error("read_data: expected %0d, actual %0d",
                           want.read_data, rsp_ch.read_data);
                    fail_cnt++;
                end
                if (rsp_ch.count !== want.count)
                begin
                    $error("count: expected %0d, actual %0d", want.count, rsp_ch.count);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        #(8 * 200000);
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
hw/rtl/ssid_pkg.sv
hw/rtl/ssid_req_if.sv
hw/rtl/ssid_rsp_if.sv
hw/rtl/ssid_cell.sv
hw/rtl/ssid_chain.sv
hw/rtl/sorted_set_insert_dedupe.sv
hw/rtl/ssid_check.sv
verif/tb_sorted_set_insert_dedupe.sv
